FILE: sv/box_iou_unit_assert.svh
// ----------------------------------------------------------------------------
// box_iou_unit_assert.svh
// Assertion macros shared by the box IoU unit.
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_UNIT_ASSERT_SVH
`define BOX_IOU_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define BIU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BIU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/biu_pkg.sv
// ----------------------------------------------------------------------------
// biu_pkg
// Widths and constants of the box IoU unit.
// ----------------------------------------------------------------------------
package biu_pkg;

   // coordinate width, unsigned Q0.CB
   localparam int CB        = 16;
   // doubled edges 2*c +/- s, signed
   localparam int EDGE_W    = CB + 3;
   // overlap in doubled units, signed, one extra bit of headroom
   localparam int OVLS_W    = EDGE_W + 1;
   // non-negative overlap, at most twice the smaller size
   localparam int OVL_W     = CB + 1;
   // intersection, four times enlarged
   localparam int INTER_W   = 2 * OVL_W;
   // single box area
   localparam int AREA_W    = 2 * CB;
   // union, four times enlarged
   localparam int UNION_W   = 2 * CB + 3;
   // shifted partial remainder
   localparam int REM_W     = UNION_W + 1;
   // ratio, unsigned Q1.CB
   localparam int RATIO_W   = CB + 1;
   // one quotient bit per divider stage
   localparam int DIV_STEPS = CB + 1;

   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << CB;

endpackage

FILE: sv/box_iou_unit.sv
// One box pair per cycle while req_ready is high; the 17-stage restoring divider, one
// quotient bit per stage, sets the depth and takes a new pair every cycle it advances.
// A two-entry output (register plus skid) keeps req_ready high while one result waits
// in the output register; req_ready is low while the skid slot holds a beat.
// Reset (synchronous, active high) empties all stages; no results are in flight after it.
// ----------------------------------------------------------------------------
// box_iou_unit
// Intersection over union of two center/size boxes, unsigned Q1.16 result,
// computed by a 3-stage geometry front end and a bit-per-stage divider.
// ----------------------------------------------------------------------------
`include "box_iou_unit_assert.svh"

module box_iou_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [biu_pkg::CB-1:0]    req_a_center_x,
   input  logic [biu_pkg::CB-1:0]    req_a_center_y,
   input  logic [biu_pkg::CB-1:0]    req_a_width,
   input  logic [biu_pkg::CB-1:0]    req_a_height,
   input  logic [biu_pkg::CB-1:0]    req_b_center_x,
   input  logic [biu_pkg::CB-1:0]    req_b_center_y,
   input  logic [biu_pkg::CB-1:0]    req_b_width,
   input  logic [biu_pkg::CB-1:0]    req_b_height,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [biu_pkg::RATIO_W-1:0] rsp_ratio,
   output logic                      rsp_disjoint
);
   import biu_pkg::*;

   // overlap on one axis in doubled units: min right edge minus max left edge
   function automatic logic signed [OVLS_W-1:0] axis_overlap(
      input logic [CB-1:0] ca,
      input logic [CB-1:0] sa,
      input logic [CB-1:0] cb,
      input logic [CB-1:0] sb
   );
      logic signed [EDGE_W-1:0] la;
      logic signed [EDGE_W-1:0] ra;
      logic signed [EDGE_W-1:0] lb;
      logic signed [EDGE_W-1:0] rb;
      logic signed [EDGE_W-1:0] lmax;
      logic signed [EDGE_W-1:0] rmin;
      la   = $signed({2'b00, ca, 1'b0}) - $signed({3'b000, sa});
      ra   = $signed({2'b00, ca, 1'b0}) + $signed({3'b000, sa});
      lb   = $signed({2'b00, cb, 1'b0}) - $signed({3'b000, sb});
      rb   = $signed({2'b00, cb, 1'b0}) + $signed({3'b000, sb});
      lmax = (la > lb) ? la : lb;
      rmin = (ra < rb) ? ra : rb;
      return OVLS_W'(rmin) - OVLS_W'(lmax);
   endfunction

   // pipeline advances whenever the skid slot is free
   logic skid_valid_ff;
   logic adv;
   assign adv       = ~skid_valid_ff;
   assign req_ready = adv;

   logic accept;
   assign accept = req_valid & req_ready;

   // ---------------- stage 1: edges and overlaps ----------------
   logic                      s1_valid_ff;
   logic [OVL_W-1:0]          s1_ow_ff;
   logic [OVL_W-1:0]          s1_oh_ff;
   logic                      s1_dis_ff;
   logic [CB-1:0]             s1_aw_ff;
   logic [CB-1:0]             s1_ah_ff;
   logic [CB-1:0]             s1_bw_ff;
   logic [CB-1:0]             s1_bh_ff;
   logic signed [OVLS_W-1:0]  s1_ow_in;
   logic signed [OVLS_W-1:0]  s1_oh_in;

   assign s1_ow_in = axis_overlap(req_a_center_x, req_a_width, req_b_center_x, req_b_width);
   assign s1_oh_in = axis_overlap(req_a_center_y, req_a_height, req_b_center_y, req_b_height);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
      if (adv) begin
         s1_ow_ff  <= s1_ow_in[OVL_W-1:0];
         s1_oh_ff  <= s1_oh_in[OVL_W-1:0];
         s1_dis_ff <= s1_ow_in[OVLS_W-1] | s1_oh_in[OVLS_W-1];
         s1_aw_ff  <= req_a_width;
         s1_ah_ff  <= req_a_height;
         s1_bw_ff  <= req_b_width;
         s1_bh_ff  <= req_b_height;
      end
   end

   // ---------------- stage 2: products ----------------
   logic                s2_valid_ff;
   logic                s2_dis_ff;
   logic [INTER_W-1:0]  s2_inter_ff;
   logic [AREA_W-1:0]   s2_area_a_ff;
   logic [AREA_W-1:0]   s2_area_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_dis_ff    <= s1_dis_ff;
         s2_inter_ff  <= s1_ow_ff * s1_oh_ff;
         s2_area_a_ff <= s1_aw_ff * s1_ah_ff;
         s2_area_b_ff <= s1_bw_ff * s1_bh_ff;
      end
   end

   // ---------------- stage 3: union ----------------
   logic                s3_valid_ff;
   logic                s3_dis_ff;
   logic                s3_zero_ff;
   logic [INTER_W-1:0]  s3_num_ff;
   logic [UNION_W-1:0]  s3_den_ff;
   logic [UNION_W-1:0]  s3_area4_in;
   logic [UNION_W-1:0]  s3_inter_ext;
   logic [UNION_W-1:0]  s3_den_in;

   always_comb begin
      s3_area4_in  = UNION_W'({s2_area_a_ff, 2'b00}) + UNION_W'({s2_area_b_ff, 2'b00});
      s3_inter_ext = UNION_W'(s2_inter_ff);
      s3_den_in    = (s3_area4_in > s3_inter_ext) ? (s3_area4_in - s3_inter_ext)
                                                  : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_dis_ff  <= s2_dis_ff;
         // disjoint or empty union forces a zero ratio at the end
         s3_zero_ff <= s2_dis_ff | (s3_den_in == '0);
         s3_num_ff  <= s2_inter_ff;
         s3_den_ff  <= s3_den_in;
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic                d_valid_ff [DIV_STEPS];
   logic                d_dis_ff   [DIV_STEPS];
   logic                d_zero_ff  [DIV_STEPS];
   logic [UNION_W-1:0]  d_rem_ff   [DIV_STEPS];
   logic [UNION_W-1:0]  d_den_ff   [DIV_STEPS];
   logic [RATIO_W-1:0]  d_q_ff     [DIV_STEPS];

   logic                d_valid_in [DIV_STEPS];
   logic                d_dis_in   [DIV_STEPS];
   logic                d_zero_in  [DIV_STEPS];
   logic [REM_W-1:0]    d_sh_in    [DIV_STEPS];
   logic [UNION_W-1:0]  d_rem_in   [DIV_STEPS];
   logic [UNION_W-1:0]  d_den_in   [DIV_STEPS];
   logic [RATIO_W-1:0]  d_qprev_in [DIV_STEPS];
   logic [RATIO_W-1:0]  d_q_in     [DIV_STEPS];
   logic                d_bit_in   [DIV_STEPS];

   // compare and subtract for each stage, fed by the stage before it
   always_comb begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (j == 0) begin
            d_valid_in[j] = s3_valid_ff;
            d_dis_in[j]   = s3_dis_ff;
            d_zero_in[j]  = s3_zero_ff;
            d_den_in[j]   = s3_den_ff;
            d_qprev_in[j] = '0;
            d_sh_in[j]    = REM_W'(s3_num_ff);
         end else begin
            d_valid_in[j] = d_valid_ff[j-1];
            d_dis_in[j]   = d_dis_ff[j-1];
            d_zero_in[j]  = d_zero_ff[j-1];
            d_den_in[j]   = d_den_ff[j-1];
            d_qprev_in[j] = d_q_ff[j-1];
            d_sh_in[j]    = {d_rem_ff[j-1], 1'b0};
         end
         d_bit_in[j] = (d_sh_in[j] >= REM_W'(d_den_in[j]));
         d_rem_in[j] = d_bit_in[j] ? UNION_W'(d_sh_in[j] - REM_W'(d_den_in[j]))
                                   : UNION_W'(d_sh_in[j]);
         d_q_in[j]   = {d_qprev_in[j][RATIO_W-2:0], d_bit_in[j]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (reset) begin
            d_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            d_valid_ff[j] <= d_valid_in[j];
         end
         if (adv) begin
            d_dis_ff[j]  <= d_dis_in[j];
            d_zero_ff[j] <= d_zero_in[j];
            d_rem_ff[j]  <= d_rem_in[j];
            d_den_ff[j]  <= d_den_in[j];
            d_q_ff[j]    <= d_q_in[j];
         end
      end
   end

   // ---------------- output register and skid slot ----------------
   logic                tail_valid;
   logic                tail_dis;
   logic [RATIO_W-1:0]  tail_ratio;

   assign tail_valid = d_valid_ff[DIV_STEPS-1];
   assign tail_dis   = d_dis_ff[DIV_STEPS-1];
   assign tail_ratio = d_zero_ff[DIV_STEPS-1] ? '0 : d_q_ff[DIV_STEPS-1];

   logic                out_valid_ff;
   logic                out_dis_ff;
   logic [RATIO_W-1:0]  out_ratio_ff;
   logic                skid_dis_ff;
   logic [RATIO_W-1:0]  skid_ratio_ff;
   logic                take;

   assign take = out_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // pipeline holds; drain the skid beat into the output register
         if (take) begin
            out_ratio_ff  <= skid_ratio_ff;
            out_dis_ff    <= skid_dis_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (~out_valid_ff | take) begin
         // output free: load the tail beat (or a bubble)
         out_valid_ff <= tail_valid;
         out_ratio_ff <= tail_ratio;
         out_dis_ff   <= tail_dis;
      end else if (tail_valid) begin
         // output busy: park the tail beat
         skid_valid_ff <= 1'b1;
         skid_ratio_ff <= tail_ratio;
         skid_dis_ff   <= tail_dis;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_ratio    = out_ratio_ff;
   assign rsp_disjoint = out_dis_ff;

   // ---------------- assertions ----------------
   `BIU_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid slot holds a beat while the output register is empty")
   `BIU_ASSERT_NOW(a_disjoint_zero, clock, reset, out_valid_ff && out_dis_ff,
      out_ratio_ff == '0, "disjoint result with nonzero ratio")
   `BIU_ASSERT_NOW(a_ratio_range, clock, reset, out_valid_ff,
      out_ratio_ff <= RATIO_ONE, "ratio above one")
   `BIU_ASSERT_NEXT(a_tail_held, clock, reset, !adv && tail_valid,
      tail_valid && $stable(tail_ratio), "stalled tail beat lost or changed")

endmodule
